FILE: rtl/core/tcta_pkg.sv
// Package: opcodes, state machine states and shared types for thread CPU-time accounting.
package tcta_pkg;
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SWITCH = 2'd1,
    OP_REPORT = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RD1,
    ST_RD2,
    ST_WR,
    ST_RPT,
    ST_DIV_AVG,
    ST_DIV_SHARE,
    ST_DIV_THR,
    ST_SPLIT,
    ST_OUT
  } state_e;

  localparam int unsigned BP_SCALE = 10000;
  localparam int unsigned PCT_SCALE = 100;
  localparam int unsigned PCT_BITS = 7;
  localparam int unsigned BP_BITS = 14;
  // x / 100 == (x * 5243) >> 19 for every x below 43699
  localparam int unsigned PCT_RECIP = 5243;
  localparam int unsigned PCT_RECIP_SHIFT = 19;
  localparam int unsigned BP_PROD_BITS = BP_BITS + 13;
endpackage

FILE: rtl/core/thread_cpu_time_accounting_top.sv
// Top level: per-thread CPU-time accounting with table RAMs and a shared divider.
// Flow after acceptance: tick and clear run only the global average divide; switch
// does the table read-modify-write, then the global average divide; report runs
// three passes of the serial divider, then the percent split.
// One request in flight; the next is taken the cycle after the result is registered.
// After reset a clearing pass zeroes the tables; no request is taken while it runs.
module thread_cpu_time_accounting_top import tcta_pkg::*; #(
  parameter int unsigned THREAD_SLOTS = 64,
  parameter int unsigned COUNTER_BITS = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              opcode_i,
  input  logic                    prev_present_i,
  input  logic [5:0]              prev_thread_i,
  input  logic                    prev_running_i,
  input  logic                    next_present_i,
  input  logic [5:0]              next_thread_i,
  input  logic [5:0]              query_thread_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [COUNTER_BITS-1:0] glob_ticks_o,
  output logic [COUNTER_BITS-1:0] glob_switches_o,
  output logic [COUNTER_BITS-1:0] avg_quantum_all_o,
  output logic [COUNTER_BITS-1:0] thread_switches_o,
  output logic [COUNTER_BITS-1:0] thread_ticks_o,
  output logic [PCT_BITS-1:0]     share_whole_o,
  output logic [PCT_BITS-1:0]     share_hundredths_o,
  output logic [COUNTER_BITS-1:0] thread_avg_quantum_o
);
  localparam int unsigned AW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int unsigned W = COUNTER_BITS;
  localparam int unsigned TW = 6;

  state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [W-1:0] tick_q, tick_d, sw_q, sw_d;
  logic [1:0] op_q;
  logic pp_q, pr_q, np_q, pin_q, nin_q, qin_q;
  logic [TW-1:0] pt_q, nt_q;
  logic [W-1:0] tsw_q, tti_q, avg_q, tavg_q;
  logic [BP_BITS-1:0] bp_q;
  logic [PCT_BITS-1:0] wh_q, hu_q;
  logic sat_q;
  logic out_valid_q;
  logic [W-1:0] r_tick, r_sw, r_avg, r_tsw, r_tti, r_tavg;
  logic [PCT_BITS-1:0] r_wh, r_hu;

  logic [AW-1:0] addr;
  logic we_sw, we_ti, we_dp;
  logic [W-1:0] wd_sw, wd_ti, wd_dp, rd_sw, rd_ti, rd_dp;
  logic div_start, div_done;
  logic [2*W-1:0] div_num;
  logic [W-1:0] div_den, div_quot;
  logic accept, out_free;
  logic [2*W-1:0] prod;
  logic [BP_PROD_BITS-1:0] bp_scaled;
  logic [PCT_BITS-1:0] bp_whole;
  logic [BP_BITS-1:0] bp_rest;

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept = in_valid_i && !in_stall_o;

  tcta_ram #(.WIDTH(W), .DEPTH(THREAD_SLOTS)) u_sw_ram (
    .clk_i, .we_i(we_sw), .addr_i(addr), .wdata_i(wd_sw), .rdata_o(rd_sw));
  tcta_ram #(.WIDTH(W), .DEPTH(THREAD_SLOTS)) u_ti_ram (
    .clk_i, .we_i(we_ti), .addr_i(addr), .wdata_i(wd_ti), .rdata_o(rd_ti));
  tcta_ram #(.WIDTH(W), .DEPTH(THREAD_SLOTS)) u_dp_ram (
    .clk_i, .we_i(we_dp), .addr_i(addr), .wdata_i(wd_dp), .rdata_o(rd_dp));

  tcta_div #(.W(W)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quot_o(div_quot));

  assign prod = (2*W)'(tti_q) * (2*W)'(BP_SCALE);

  assign bp_scaled = BP_PROD_BITS'(bp_q) * BP_PROD_BITS'(PCT_RECIP);
  assign bp_whole = PCT_BITS'(bp_scaled >> PCT_RECIP_SHIFT);
  assign bp_rest = bp_q - BP_BITS'(bp_whole) * BP_BITS'(PCT_SCALE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:     if (clr_q == AW'(THREAD_SLOTS - 1)) state_d = ST_IDLE;
      ST_IDLE:      if (accept) begin
        case (op_e'(opcode_i))
          OP_SWITCH: state_d = ST_RD1;
          OP_REPORT: state_d = ST_RPT;
          default:   state_d = ST_DIV_AVG;
        endcase
      end
      ST_RD1:       state_d = ST_RD2;
      ST_RD2:       state_d = ST_WR;
      ST_WR:        state_d = ST_DIV_AVG;
      ST_RPT:       state_d = ST_DIV_AVG;
      ST_DIV_AVG:   if (div_done) state_d = (op_q == OP_REPORT) ? ST_DIV_SHARE : ST_OUT;
      ST_DIV_SHARE: if (div_done) state_d = ST_DIV_THR;
      ST_DIV_THR:   if (div_done) state_d = ST_SPLIT;
      ST_SPLIT:     state_d = ST_OUT;
      ST_OUT:       if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    addr = AW'(query_thread_i);
    we_sw = 1'b0;
    we_ti = 1'b0;
    we_dp = 1'b0;
    wd_sw = rd_sw + W'(1);
    wd_ti = rd_ti + (tick_q - rd_dp);
    wd_dp = tick_q;
    div_start = 1'b0;
    div_num = (2*W)'(tick_q);
    div_den = sw_q;
    clr_d = clr_q;
    tick_d = tick_q;
    sw_d = sw_q;
    case (state_q)
      ST_CLEAR: begin
        addr = clr_q;
        we_sw = 1'b1;
        we_ti = 1'b1;
        we_dp = 1'b1;
        wd_sw = '0;
        wd_ti = '0;
        wd_dp = '0;
        clr_d = clr_q + 1'b1;
      end
      ST_IDLE: begin
        addr = AW'(prev_thread_i);
        if (accept) begin
          case (op_e'(opcode_i))
            OP_TICK:  tick_d = tick_q + W'(1);
            OP_CLEAR: begin
              tick_d = '0;
              sw_d = '0;
            end
            default: ;
          endcase
          if (op_e'(opcode_i) == OP_REPORT) addr = AW'(query_thread_i);
        end
      end
      ST_RD1: begin
        addr = AW'(nt_q);
        we_ti = pp_q && pr_q && pin_q;
        addr = AW'(pt_q);
      end
      ST_RD2: begin
        addr = AW'(nt_q);
      end
      ST_WR: begin
        addr = AW'(nt_q);
        we_sw = np_q && nin_q;
        we_dp = np_q && nin_q;
        sw_d = sw_q + W'(1);
      end
      ST_RPT: begin
        div_start = 1'b1;
      end
      ST_DIV_AVG: if (div_done && op_q == OP_REPORT) begin
        div_start = 1'b1;
        div_num = prod;
        div_den = tick_q;
      end
      ST_DIV_SHARE: if (div_done) begin
        div_start = 1'b1;
        div_num = (2*W)'(tti_q);
        div_den = tsw_q;
      end
      default: ;
    endcase
    if (state_q == ST_IDLE && accept && op_e'(opcode_i) != OP_SWITCH &&
        op_e'(opcode_i) != OP_REPORT) begin
      div_start = 1'b1;
      div_num = (2*W)'(tick_d);
      div_den = sw_d;
    end
    if (state_q == ST_WR) begin
      div_start = 1'b1;
      div_num = (2*W)'(tick_q);
      div_den = sw_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q <= '0;
      tick_q <= '0;
      sw_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      tick_q <= tick_d;
      sw_q <= sw_d;
      if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= opcode_i;
      pp_q <= prev_present_i;
      pr_q <= prev_running_i;
      np_q <= next_present_i;
      pt_q <= prev_thread_i;
      nt_q <= next_thread_i;
      pin_q <= (32'(prev_thread_i) < THREAD_SLOTS);
      nin_q <= (32'(next_thread_i) < THREAD_SLOTS);
      qin_q <= (32'(query_thread_i) < THREAD_SLOTS);
    end
    if (state_q == ST_RPT) begin
      tsw_q <= qin_q ? rd_sw : '0;
      tti_q <= qin_q ? rd_ti : '0;
    end
    if (state_q == ST_RPT) sat_q <= qin_q && (rd_ti >= tick_q);
    if (state_q == ST_DIV_AVG && div_done) avg_q <= (tick_q == '0) ? '0 : div_quot;
    if (state_q == ST_DIV_SHARE && div_done) bp_q <= BP_BITS'(div_quot);
    if (state_q == ST_DIV_THR && div_done) tavg_q <= div_quot;
    if (state_q == ST_SPLIT) begin
      if (tick_q == '0) begin
        wh_q <= '0;
        hu_q <= '0;
      end else if (sat_q) begin
        wh_q <= PCT_BITS'(PCT_SCALE);
        hu_q <= '0;
      end else begin
        wh_q <= bp_whole;
        hu_q <= PCT_BITS'(bp_rest);
      end
    end
    if (state_q == ST_OUT && out_free) begin
      r_tick <= tick_q;
      r_sw <= sw_q;
      r_avg <= avg_q;
      if (op_q == OP_REPORT) begin
        r_tsw <= tsw_q;
        r_tti <= tti_q;
        r_wh <= wh_q;
        r_hu <= hu_q;
        r_tavg <= tavg_q;
      end else begin
        r_tsw <= '0;
        r_tti <= '0;
        r_wh <= '0;
        r_hu <= '0;
        r_tavg <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign glob_ticks_o = r_tick;
  assign glob_switches_o = r_sw;
  assign avg_quantum_all_o = r_avg;
  assign thread_switches_o = r_tsw;
  assign thread_ticks_o = r_tti;
  assign share_whole_o = r_wh;
  assign share_hundredths_o = r_hu;
  assign thread_avg_quantum_o = r_tavg;
endmodule

FILE: rtl/core/tcta_ram.sv
// Generic single-port synchronous RAM with registered read.
module tcta_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

FILE: rtl/core/tcta_div.sv
// Radix-2 restoring divider, numerator up to 2*W bits, one quotient bit per cycle.
module tcta_div #(
  parameter int unsigned W = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [2*W-1:0] num_i,
  input  logic [W-1:0]   den_i,
  output logic           done_o,
  output logic [W-1:0]   quot_o
);
  localparam int unsigned CW = $clog2(2 * W + 1);

  logic [2*W-1:0] num_q, num_d;
  logic [W-1:0]   den_q, den_d, rem_q, rem_d, quot_q, quot_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           busy_q, busy_d, done_q, done_d;
  logic [W:0]     trial;

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, num_q[2*W-1]};
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      quot_d = '0;
      cnt_d  = CW'(2 * W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = num_q << 1;
      if (trial >= {1'b0, den_q}) begin
        rem_d  = W'(trial - {1'b0, den_q});
        quot_d = {quot_q[W-2:0], 1'b1};
      end else begin
        rem_d  = trial[W-1:0];
        quot_d = {quot_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = (den_q == '0) ? '0 : quot_q;
endmodule

FILE: rtl/core/tcta_checker.sv
// Port-level checker for the thread CPU-time accounting top level, with its bind.
module tcta_checker import tcta_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [6:0] share_whole_o,
  input logic [6:0] share_hundredths_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result dropped under stall");
  a_share_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> share_whole_o <= 7'd100) else $error("share above 100");
  a_hund_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> share_hundredths_o <= 7'd99) else $error("hundredths above 99");
  a_sat_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && share_whole_o == 7'd100 |-> share_hundredths_o == 7'd0)
    else $error("saturated share has hundredths");
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o) else $error("second request taken in flight");
endmodule

bind thread_cpu_time_accounting_top tcta_checker u_tcta_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .share_whole_o, .share_hundredths_o);
